FILE: rtl/e2e44_pkg.sv
// shared types, constants and helper functions of the e2e profile 44 checker
`default_nettype none

package e2e44_pkg;

   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY_REFL = 32'hC8DF_352F;
   localparam logic [15:0] COUNTER_MAX   = 16'hFFFF;

   localparam int          HDR_BYTES   = 12;
   localparam logic [3:0]  HDR_LEN_END = 4'd2;
   localparam logic [3:0]  HDR_CTR_END = 4'd4;
   localparam logic [3:0]  HDR_ID_END  = 4'd8;

   localparam int          CSR_DATA_W  = 32;
   localparam int          CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_ID       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LENGTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DELTA     = 3'd4;

   localparam logic [31:0] RST_DATA_ID       = 32'd0;
   localparam logic [11:0] RST_HEADER_OFFSET = 12'd0;
   localparam logic [11:0] RST_MIN_LENGTH    = 12'd12;
   localparam logic [11:0] RST_MAX_LENGTH    = 12'd4095;
   localparam logic [15:0] RST_MAX_DELTA     = 16'd1;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_OKSOMELOST = 3'd1,
      ST_ERROR      = 3'd2,
      ST_REPEATED   = 3'd3,
      ST_NONEWDATA  = 3'd4,
      ST_WRONGSEQ   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      GEN_OK        = 3'd0,
      GEN_ERROR     = 3'd1,
      GEN_REPEATED  = 3'd2,
      GEN_NONEWDATA = 3'd3,
      GEN_WRONGSEQ  = 3'd4
   } generic_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       no_new_data;
   } req_type;

   typedef struct packed {
      logic       return_code;
      logic [2:0] check_result;
      logic [2:0] generic_result;
      logic [15:0] seen_counter;
   } rsp_type;

   typedef struct packed {
      logic [31:0] data_id;
      logic [11:0] header_offset;
      logic [11:0] min_length;
      logic [11:0] max_length;
      logic [15:0] max_delta;
   } cfg_type;

   // classified message handed from front to back
   typedef struct packed {
      logic        no_new_data;
      logic        len_oob;
      logic        fail;
      logic [15:0] counter;
   } job_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY_REFL;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic generic_type map_generic(input status_type st);
      generic_type g;
      case (st)
         ST_OK:         g = GEN_OK;
         ST_OKSOMELOST: g = GEN_OK;
         ST_REPEATED:   g = GEN_REPEATED;
         ST_NONEWDATA:  g = GEN_NONEWDATA;
         ST_WRONGSEQ:   g = GEN_WRONGSEQ;
         default:       g = GEN_ERROR;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/e2e44_front.sv
// front end: byte accumulation, crc, header capture and message classification
`default_nettype none

module e2e44_front import e2e44_pkg::*; #(
   parameter int MAX_MESSAGE_BYTES = 4095
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   input  wire logic    job_full,
   output logic         job_push,
   output job_type      job_data
);

   localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 2);
   localparam int CW    = (CNT_W > 16) ? CNT_W : 16;
   localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_MESSAGE_BYTES + 1);
   localparam logic [CW-1:0]    MAX_LEN = CW'(MAX_MESSAGE_BYTES);
   localparam logic [CW-1:0]    HDR_W   = CW'(HDR_BYTES);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      crc_ff, crc_in;
   logic [15:0]      hlen_ff, hlen_in;
   logic [15:0]      hctr_ff, hctr_in;
   logic [31:0]      hid_ff, hid_in;
   logic [31:0]      hcrc_ff, hcrc_in;

   logic             accept;
   logic [CW-1:0]    pos, off, rel, len;
   logic             in_hdr;
   logic [3:0]       k;
   logic [CNT_W-1:0] count_upd;
   logic [31:0]      crc_upd;
   logic [15:0]      hlen_upd, hctr_upd;
   logic [31:0]      hid_upd, hcrc_upd;

   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pos    = CW'(count_ff);
      off    = CW'(cfg.header_offset);
      rel    = pos - off;
      k      = rel[3:0];
      in_hdr = (pos >= off) && (pos < off + HDR_W);

      hlen_upd = hlen_ff;
      hctr_upd = hctr_ff;
      hid_upd  = hid_ff;
      hcrc_upd = hcrc_ff;
      if (in_hdr) begin
         if (k < HDR_LEN_END) begin
            hlen_upd = {hlen_ff[7:0], req_data.data_byte};
         end else if (k < HDR_CTR_END) begin
            hctr_upd = {hctr_ff[7:0], req_data.data_byte};
         end else if (k < HDR_ID_END) begin
            hid_upd = {hid_ff[23:0], req_data.data_byte};
         end else begin
            hcrc_upd = {hcrc_ff[23:0], req_data.data_byte};
         end
      end

      // crc bytes themselves stay out of the crc
      crc_upd   = (in_hdr && (k >= HDR_ID_END)) ? crc_ff : crc_byte(crc_ff, req_data.data_byte);
      count_upd = (count_ff < CNT_CAP) ? count_ff + 1'b1 : count_ff;
      len       = CW'(count_upd);

      job_push             = accept && (req_data.no_new_data || req_data.last_byte);
      job_data.no_new_data = req_data.no_new_data;
      job_data.len_oob     = (len < CW'(cfg.min_length)) || (len > CW'(cfg.max_length))
                             || (len > MAX_LEN);
      job_data.fail        = (len < off + HDR_W) || ((crc_upd ^ CRC_INIT) != hcrc_upd)
                             || (hid_upd != cfg.data_id) || (CW'(hlen_upd) != len);
      job_data.counter     = hctr_upd;

      count_in = count_ff;
      crc_in   = crc_ff;
      hlen_in  = hlen_ff;
      hctr_in  = hctr_ff;
      hid_in   = hid_ff;
      hcrc_in  = hcrc_ff;
      if (accept) begin
         if (req_data.no_new_data || req_data.last_byte) begin
            count_in = '0;
            crc_in   = CRC_INIT;
            hlen_in  = '0;
            hctr_in  = '0;
            hid_in   = '0;
            hcrc_in  = '0;
         end else begin
            count_in = count_upd;
            crc_in   = crc_upd;
            hlen_in  = hlen_upd;
            hctr_in  = hctr_upd;
            hid_in   = hid_upd;
            hcrc_in  = hcrc_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= CRC_INIT;
         hlen_ff  <= '0;
         hctr_ff  <= '0;
         hid_ff   <= '0;
         hcrc_ff  <= '0;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         hlen_ff  <= hlen_in;
         hctr_ff  <= hctr_in;
         hid_ff   <= hid_in;
         hcrc_ff  <= hcrc_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/e2e44_queue.sv
// two-entry queue of classified messages between front and back
`default_nettype none

module e2e44_queue import e2e44_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output job_type      pop_data
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == FULL_CNT);
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/e2e44_back.sv
// back end: sequence check, stored status and response register
`default_nettype none

module e2e44_back import e2e44_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    job_valid,
   input  wire job_type job_data,
   output logic         job_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic [15:0] last_counter_ff, last_counter_in;
   status_type  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [15:0] delta;
   logic        rc;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      job_pop = job_valid && (!rsp_valid_ff || rsp_ready);
      delta   = job_data.counter - last_counter_ff;

      rc              = 1'b0;
      status_in       = status_ff;
      last_counter_in = last_counter_ff;
      if (job_pop) begin
         if (job_data.no_new_data) begin
            status_in = ST_NONEWDATA;
         end else if (job_data.len_oob) begin
            rc = 1'b1;
         end else if (job_data.fail) begin
            status_in = ST_ERROR;
         end else begin
            last_counter_in = job_data.counter;
            if (delta > cfg.max_delta) begin
               status_in = ST_WRONGSEQ;
            end else if (delta == 16'd0) begin
               status_in = ST_REPEATED;
            end else if (delta == 16'd1) begin
               status_in = ST_OK;
            end else begin
               status_in = ST_OKSOMELOST;
            end
         end
      end

      rsp_data_in                = rsp_data_ff;
      rsp_valid_in               = rsp_valid_ff && !rsp_ready;
      if (job_pop) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.return_code    = rc;
         rsp_data_in.check_result   = status_in;
         rsp_data_in.generic_result = rc ? GEN_ERROR : map_generic(status_in);
         rsp_data_in.seen_counter   = last_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_counter_ff <= COUNTER_MAX;
         status_ff       <= ST_ERROR;
         rsp_valid_ff    <= 1'b0;
      end else begin
         last_counter_ff <= last_counter_in;
         status_ff       <= status_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: rtl/e2e_profile44_checker_unit.sv
// top level of the e2e profile 44 receive checker
//
// requests arrive on req_valid/req_ready/req_data, one message byte per request,
// with last_byte on the final byte, or a single request with no_new_data set.
// one response leaves on rsp_valid/rsp_ready/rsp_data for every last byte and
// every no-new-data request; other bytes give none.
// one request is taken per cycle while the queue is not full. the front end
// updates the crc and header fields for a byte in the cycle it is taken; a
// finished message then passes through the queue and the response register.
// a two-entry queue sits between front end and back end, and the back end
// holds its response in an output register, so the front end keeps taking
// bytes while a response waits; req_ready drops only when the queue is full.
// the user writes registers through csr_we/csr_index/csr_wdata only while idle; the block does not enforce it.
// synchronous reset restores the registers to their defaults, sets the stored
// counter to 0xffff and the stored status to error, and drops any partial
// message and any pending response.
`default_nettype none

module e2e_profile44_checker_unit import e2e44_pkg::*; #(
   parameter int MAX_MESSAGE_BYTES = 4095
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg_ff, cfg_in;

   logic    job_push, job_full, job_pop, job_valid;
   job_type push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DATA_ID:       cfg_in.data_id       = csr_wdata;
            CSR_HEADER_OFFSET: cfg_in.header_offset = csr_wdata[11:0];
            CSR_MIN_LENGTH:    cfg_in.min_length    = csr_wdata[11:0];
            CSR_MAX_LENGTH:    cfg_in.max_length    = csr_wdata[11:0];
            CSR_MAX_DELTA:     cfg_in.max_delta     = csr_wdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.data_id       <= RST_DATA_ID;
         cfg_ff.header_offset <= RST_HEADER_OFFSET;
         cfg_ff.min_length    <= RST_MIN_LENGTH;
         cfg_ff.max_length    <= RST_MAX_LENGTH;
         cfg_ff.max_delta     <= RST_MAX_DELTA;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   e2e44_front #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_full  (job_full),
      .job_push  (job_push),
      .job_data  (push_data)
   );

   e2e44_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_valid (job_valid),
      .pop_data  (pop_data)
   );

   e2e44_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job_data  (pop_data),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: verif/e2e_profile44_checker_unit_tb.sv
// self-checking testbench for the e2e profile 44 receive checker
module e2e_profile44_checker_unit_tb;
   import e2e44_pkg::*;

   localparam int unsigned MSG_BYTES_MAX = 4095;

   typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_ID, FLAW_LEN, FLAW_CUT} flaw_type;

   class e2e44_verdict_board;
      cfg_type     cfg;
      logic [15:0] last_cnt;
      status_type  status;
      logic [31:0] crc;
      int unsigned nbytes;
      logic [15:0] hdr_len;
      logic [15:0] hdr_cnt;
      logic [31:0] hdr_id;
      logic [31:0] hdr_crc;
      rsp_type     verdicts_due[$];
      int unsigned mismatches;
      int unsigned verdicts_checked;
      int unsigned length_rejects;
      int unsigned status_seen[8];

      function new();
         cfg.data_id       = RST_DATA_ID;
         cfg.header_offset = RST_HEADER_OFFSET;
         cfg.min_length    = RST_MIN_LENGTH;
         cfg.max_length    = RST_MAX_LENGTH;
         cfg.max_delta     = RST_MAX_DELTA;
         last_cnt = COUNTER_MAX;
         status   = ST_ERROR;
         restart_message();
      endfunction

      static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
         logic fb;
         for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = {1'b0, c[31:1]};
            if (fb) begin
               c = c ^ CRC_POLY_REFL;
            end
         end
         return c;
      endfunction

      function void restart_message();
         crc     = CRC_INIT;
         nbytes  = 0;
         hdr_len = '0;
         hdr_cnt = '0;
         hdr_id  = '0;
         hdr_crc = '0;
      endfunction

      function void take_byte(logic [7:0] b);
         int unsigned p;
         int unsigned off;
         p   = nbytes;
         off = cfg.header_offset;
         if (p >= off && p < off + 12) begin
            if (p - off < 2) begin
               hdr_len = {hdr_len[7:0], b};
            end else if (p - off < 4) begin
               hdr_cnt = {hdr_cnt[7:0], b};
            end else if (p - off < 8) begin
               hdr_id = {hdr_id[23:0], b};
            end else begin
               hdr_crc = {hdr_crc[23:0], b};
            end
         end
         if (!(p >= off + 8 && p < off + 12)) begin
            crc = crc_step(crc, b);
         end
         if (nbytes < MSG_BYTES_MAX + 1) begin
            nbytes++;
         end
      endfunction

      function void classify_counter(logic [15:0] rx);
         logic [15:0] delta;
         delta = rx - last_cnt;
         if (delta > cfg.max_delta) begin
            status = ST_WRONGSEQ;
         end else if (delta == 16'd0) begin
            status = ST_REPEATED;
         end else if (delta == 16'd1) begin
            status = ST_OK;
         end else begin
            status = ST_OKSOMELOST;
         end
         last_cnt = rx;
      endfunction

      function void take_request(req_type r);
         logic        rc;
         int unsigned len;
         rsp_type     v;
         rc = 1'b0;
         if (r.no_new_data) begin
            restart_message();
            status = ST_NONEWDATA;
         end else begin
            take_byte(r.data_byte);
            if (!r.last_byte) begin
               return;
            end
            len = nbytes;
            if (len < cfg.min_length || len > cfg.max_length || len > MSG_BYTES_MAX) begin
               rc = 1'b1;
            end else if (len < cfg.header_offset + 12) begin
               status = ST_ERROR;
            end else if ((crc ^ CRC_INIT) != hdr_crc || hdr_id != cfg.data_id) begin
               status = ST_ERROR;
            end else if (hdr_len != len) begin
               status = ST_ERROR;
            end else begin
               classify_counter(hdr_cnt);
            end
            restart_message();
         end
         v.return_code  = rc;
         v.check_result = status;
         v.seen_counter = last_cnt;
         if (rc) begin
            v.generic_result = GEN_ERROR;
         end else begin
            case (status)
               ST_OK, ST_OKSOMELOST: v.generic_result = GEN_OK;
               ST_REPEATED:          v.generic_result = GEN_REPEATED;
               ST_NONEWDATA:         v.generic_result = GEN_NONEWDATA;
               ST_WRONGSEQ:          v.generic_result = GEN_WRONGSEQ;
               default:              v.generic_result = GEN_ERROR;
            endcase
         end
         verdicts_due.push_back(v);
      endfunction

      function void compare_field(string what, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         end
      endfunction

      function void match_verdict(rsp_type got);
         rsp_type want;
         if (verdicts_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response %0h", $time, got);
            return;
         end
         want = verdicts_due.pop_front();
         verdicts_checked++;
         if (want.return_code) begin
            length_rejects++;
         end else begin
            status_seen[want.check_result]++;
         end
         compare_field("return_code", want.return_code, got.return_code);
         compare_field("check_result", want.check_result, got.check_result);
         compare_field("generic_result", want.generic_result, got.generic_result);
         compare_field("seen_counter", want.seen_counter, got.seen_counter);
      endfunction

      function int unsigned verdicts_left();
         return verdicts_due.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   e2e44_verdict_board board;
   cfg_type            cur_cfg;
   bit                 idle_on;
   int                 stall_left;
   int unsigned        n_requests;
   int unsigned        n_settings;

   e2e_profile44_checker_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic cfg_type make_cfg(logic [31:0] id, int unsigned off, int unsigned mn,
                                        int unsigned mx, int unsigned dl);
      cfg_type c;
      c.data_id       = id;
      c.header_offset = off[11:0];
      c.min_length    = mn[11:0];
      c.max_length    = mx[11:0];
      c.max_delta     = dl[15:0];
      return c;
   endfunction

   task automatic send_req(req_type r);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.take_request(r);
      n_requests++;
   endtask

   task automatic send_nnd();
      req_type r;
      r.data_byte   = 8'($urandom);
      r.last_byte   = 1'($urandom);
      r.no_new_data = 1'b1;
      send_req(r);
   endtask

   task automatic send_message(int unsigned len, logic [15:0] step, flaw_type flaw);
      logic [7:0]  msg[];
      int unsigned off;
      logic [15:0] len_field;
      logic [15:0] ctr;
      logic [31:0] id;
      logic [31:0] c;
      req_type     r;
      off = cur_cfg.header_offset;
      msg = new[len];
      for (int p = 0; p < len; p++) begin
         msg[p] = 8'($urandom);
      end
      if (len >= off + 12) begin
         len_field = len[15:0];
         if (flaw == FLAW_LEN) begin
            len_field = len_field ^ (16'd1 << $urandom_range(0, 15));
         end
         ctr = board.last_cnt + step;
         id  = cur_cfg.data_id;
         if (flaw == FLAW_ID) begin
            id = id ^ (32'd1 << $urandom_range(0, 31));
         end
         {msg[off], msg[off+1]} = len_field;
         {msg[off+2], msg[off+3]} = ctr;
         {msg[off+4], msg[off+5], msg[off+6], msg[off+7]} = id;
         c = CRC_INIT;
         for (int p = 0; p < len; p++) begin
            if (!(p >= off + 8 && p < off + 12)) begin
               c = e2e44_verdict_board::crc_step(c, msg[p]);
            end
         end
         c = c ^ CRC_INIT;
         if (flaw == FLAW_CRC) begin
            c = c ^ (32'd1 << $urandom_range(0, 31));
         end
         {msg[off+8], msg[off+9], msg[off+10], msg[off+11]} = c;
      end
      for (int p = 0; p < len; p++) begin
         if (flaw == FLAW_CUT && p == len / 2) begin
            send_nnd();
            return;
         end
         r.data_byte   = msg[p];
         r.last_byte   = (p == len - 1);
         r.no_new_data = 1'b0;
         send_req(r);
      end
   endtask

   // wait for the block to drain before touching the registers
   task automatic settle();
      req_valid <= 1'b0;
      while (board.verdicts_left() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_config(cfg_type c);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_DATA_ID;
      csr_wdata <= c.data_id;
      @(posedge clock);
      csr_index <= CSR_HEADER_OFFSET;
      csr_wdata <= {20'd0, c.header_offset};
      @(posedge clock);
      csr_index <= CSR_MIN_LENGTH;
      csr_wdata <= {20'd0, c.min_length};
      @(posedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_wdata <= {20'd0, c.max_length};
      @(posedge clock);
      csr_index <= CSR_MAX_DELTA;
      csr_wdata <= {16'd0, c.max_delta};
      @(posedge clock);
      csr_we <= 1'b0;
      cur_cfg   = c;
      board.cfg = c;
      n_settings++;
   endtask

   task automatic random_message(bit quiet);
      int unsigned off;
      int unsigned len;
      int unsigned pick;
      logic [15:0] step;
      idle_on = !quiet && ($urandom_range(0, 3) != 0);
      off = cur_cfg.header_offset;
      len = off + 12 + $urandom_range(0, 12);
      case ($urandom_range(0, 7))
         0:       step = 16'd0;
         1, 2, 3: step = 16'd1;
         4:       step = 16'd2;
         5:       step = cur_cfg.max_delta;
         6:       step = cur_cfg.max_delta + 16'd1;
         default: step = 16'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
         send_message(len, step, FLAW_NONE);
      end else if (pick < 75) begin
         send_message(len, step, FLAW_CRC);
      end else if (pick < 81) begin
         send_message(len, step, FLAW_ID);
      end else if (pick < 86) begin
         send_message(len, step, FLAW_LEN);
      end else if (pick < 91) begin
         send_message(len, step, FLAW_CUT);
      end else if (pick < 95) begin
         send_nnd();
      end else begin
         send_message($urandom_range(1, off + 11), step, FLAW_NONE);
      end
   endtask

   // response side: check and apply random back-pressure
   initial begin
      rsp_ready  <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            board.match_verdict(rsp_data);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!reset && idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #5000000;
      $display("e2e_profile44_checker_unit test failed");
      $finish;
   end

   initial begin
      cfg_type     c;
      int unsigned off;
      int unsigned target;
      board      = new();
      cur_cfg    = board.cfg;
      idle_on    = 1'b0;
      n_requests = 0;
      n_settings = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_DATA_ID;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults
      write_config(make_cfg(RST_DATA_ID, RST_HEADER_OFFSET, RST_MIN_LENGTH,
                            RST_MAX_LENGTH, RST_MAX_DELTA));
      idle_on = 1'b1;
      send_nnd();
      send_message(12, 16'd1, FLAW_NONE);
      send_message(12, 16'd0, FLAW_NONE);
      send_message(14, 16'd1, FLAW_NONE);
      send_message(15, 16'd2, FLAW_NONE);
      send_message(16, 16'd1, FLAW_CRC);
      send_message(16, 16'd1, FLAW_ID);
      send_message(16, 16'd1, FLAW_LEN);
      send_message(20, 16'd1, FLAW_CUT);
      send_message(11, 16'd1, FLAW_NONE);

      // header further out, all ones id, widest counter step
      write_config(make_cfg(32'hFFFF_FFFF, 100, 0, 4095, 16'hFFFF));
      send_message(112, 16'hFFFF, FLAW_NONE);
      send_message(20, 16'd1, FLAW_NONE);

      // zero step allowed only, exact length window
      write_config(make_cfg(32'd0, 0, 12, 12, 0));
      send_message(12, 16'd0, FLAW_NONE);
      send_message(12, 16'd1, FLAW_NONE);
      send_message(13, 16'd0, FLAW_NONE);

      // crossed bounds
      write_config(make_cfg(32'd0, 0, 4095, 0, 1));
      send_message(12, 16'd1, FLAW_NONE);
      send_nnd();

      for (int ph = 0; ph < 6; ph++) begin
         off = $urandom_range(0, 8);
         case (ph)
            0:       c = make_cfg($urandom, off, 12, 4095, 1);
            1:       c = make_cfg(32'hFFFF_FFFF, 0, 0, 4095, 0);
            2:       c = make_cfg($urandom, off, 0, off + 18, 16'hFFFF);
            3:       c = make_cfg(32'd0, off, off + 14, 4095, $urandom_range(2, 5));
            4:       c = make_cfg($urandom, off, 4095, 0, 1);
            default: c = make_cfg($urandom, off, 12, 4095, 3);
         endcase
         write_config(c);
         target = n_requests + ((ph == 4) ? 60 : 250);
         while (n_requests < target) begin
            random_message(ph == 5);
         end
      end

      idle_on = 1'b0;
      settle();
      $display("covered %0d requests, %0d responses, %0d register settings",
               n_requests, board.verdicts_checked, n_settings);
      $display("length rejects %0d, ok %0d, some lost %0d, error %0d, repeated %0d, "
               , board.length_rejects, board.status_seen[ST_OK],
               board.status_seen[ST_OKSOMELOST], board.status_seen[ST_ERROR],
               board.status_seen[ST_REPEATED],
               "no new data %0d, wrong sequence %0d",
               board.status_seen[ST_NONEWDATA], board.status_seen[ST_WRONGSEQ]);
      if (board.mismatches == 0 && board.verdicts_left() == 0) begin
         $display("e2e_profile44_checker_unit test passed");
      end else begin
         $display("e2e_profile44_checker_unit test failed");
      end
      $finish;
   end

endmodule
